// ===== sv/lbpg_pkg.sv =====
`timescale 1ns / 1ps

package lbpg_pkg;

   // Command codes carried in req_tuser
   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_ON      = 3'd1,
      ACT_OFF     = 3'd2,
      ACT_TOGGLE  = 3'd3,
      ACT_BLINK   = 3'd4,
      ACT_PATTERN = 3'd5,
      ACT_FLASH   = 3'd6,
      ACT_PAUSE   = 3'd7
   } action_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ON_TIME   = 2'd0,
      CSR_OFF_TIME  = 2'd1,
      CSR_GROUP_GAP = 2'd2,
      CSR_END_GAP   = 2'd3
   } csr_index_type;

   // Operating mode, one-hot
   typedef enum logic [3:0] {
      MODE_OFF     = 4'b0001,
      MODE_ON      = 4'b0010,
      MODE_BLINK   = 4'b0100,
      MODE_PATTERN = 4'b1000
   } mode_type;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [15:0] ON_TIME_RST   = 16'd100;
   localparam logic [15:0] OFF_TIME_RST  = 16'd100;
   localparam logic [15:0] GROUP_GAP_RST = 16'd200;
   localparam logic [15:0] END_GAP_RST   = 16'd400;

   typedef struct packed {
      logic [15:0] on_time;
      logic [15:0] off_time;
      logic [15:0] group_gap;
      logic [15:0] end_gap;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  first_count;
      logic [7:0]  second_count;
      logic        repeat_pattern;
      logic [15:0] duration;
   } item_type;

   // Last member lands in bit 0
   typedef struct packed {
      logic is_lit_mode;
      logic led_changed;
      logic led_level;
   } flags_type;

endpackage

// ===== sv/lbpg_csr.sv =====
`timescale 1ns / 1ps

module lbpg_csr import lbpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ON_TIME:   cfg_in.on_time   = csr_data;
            CSR_OFF_TIME:  cfg_in.off_time  = csr_data;
            CSR_GROUP_GAP: cfg_in.group_gap = csr_data;
            CSR_END_GAP:   cfg_in.end_gap   = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_time   <= ON_TIME_RST;
         cfg_ff.off_time  <= OFF_TIME_RST;
         cfg_ff.group_gap <= GROUP_GAP_RST;
         cfg_ff.end_gap   <= END_GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/lbpg_core.sv =====
`timescale 1ns / 1ps

module lbpg_core import lbpg_pkg::*; #(
   parameter int COUNT_BITS = 8,
   parameter int TIME_BITS  = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_vld,
   input  item_type  item,
   input  cfg_type   cfg,
   output flags_type flags
);

   logic [TIME_BITS-1:0]  now_ff, last_ff, ov_start_ff;
   logic [15:0]           ov_len_ff;
   logic                  ov_lvl_ff;
   mode_type              mode_ff;
   logic                  level_ff, driven_ff, repeat_ff;
   logic [COUNT_BITS-1:0] first_left_ff, second_left_ff, first_total_ff, second_total_ff;

   logic [TIME_BITS-1:0]  now_in, last_in, ov_start_in;
   logic [15:0]           ov_len_in;
   logic                  ov_lvl_in;
   mode_type              mode_in;
   logic                  level_in, repeat_in;
   logic [COUNT_BITS-1:0] first_left_in, second_left_in, first_total_in, second_total_in;

   logic                  is_tick, is_overlay, ov_act;
   logic [TIME_BITS-1:0]  dt;
   logic [COUNT_BITS-1:0] c1, c2;

   assign c1 = COUNT_BITS'(item.first_count);
   assign c2 = COUNT_BITS'(item.second_count);

   // Clock and overlay update; flash and pause restart the overlay now
   assign is_tick     = (item.action == ACT_TICK);
   assign is_overlay  = (item.action == ACT_FLASH) || (item.action == ACT_PAUSE);
   assign now_in      = is_tick ? now_ff + TIME_BITS'(1) : now_ff;
   assign ov_start_in = is_overlay ? now_ff : ov_start_ff;
   assign ov_len_in   = is_overlay ? item.duration : ov_len_ff;
   assign ov_lvl_in   = is_overlay ? (item.action == ACT_FLASH) : ov_lvl_ff;
   assign ov_act      = (TIME_BITS'(now_in - ov_start_in)) <= TIME_BITS'(ov_len_in);

   // Command handling, then one timing step
   always_comb begin
      mode_in         = mode_ff;
      level_in        = level_ff;
      last_in         = last_ff;
      repeat_in       = repeat_ff;
      first_left_in   = first_left_ff;
      second_left_in  = second_left_ff;
      first_total_in  = first_total_ff;
      second_total_in = second_total_ff;

      unique case (item.action)
         ACT_TICK: begin
         end
         ACT_ON: begin
            mode_in  = MODE_ON;
            level_in = 1'b1;
         end
         ACT_OFF: begin
            mode_in  = MODE_OFF;
            level_in = 1'b0;
         end
         ACT_TOGGLE: begin
            // overlay untouched and clock unchanged, so ov_act is the prior state
            if (ov_act || mode_ff != MODE_OFF) begin
               mode_in  = MODE_OFF;
               level_in = 1'b0;
            end else begin
               mode_in  = MODE_ON;
               level_in = 1'b1;
            end
         end
         ACT_BLINK: begin
            if (mode_ff != MODE_BLINK) begin
               mode_in  = MODE_BLINK;
               level_in = 1'b1;
               last_in  = now_ff;
            end
         end
         ACT_PATTERN: begin
            repeat_in = item.repeat_pattern;
            if (mode_ff != MODE_PATTERN || first_total_ff != c1 || second_total_ff != c2) begin
               mode_in         = MODE_PATTERN;
               first_total_in  = c1;
               second_total_in = c2;
               first_left_in   = c1;
               second_left_in  = c2;
               level_in        = 1'b1;
               last_in         = now_ff;
            end
         end
         ACT_FLASH, ACT_PAUSE: begin
         end
      endcase

      dt = now_in - last_in;

      if (ov_act) begin
         level_in = ov_lvl_in;
      end else begin
         unique case (mode_in)
            MODE_ON:  level_in = 1'b1;
            MODE_OFF: level_in = 1'b0;
            MODE_BLINK: begin
               if (level_in && dt >= TIME_BITS'(cfg.on_time)) begin
                  level_in = 1'b0;
                  last_in  = now_in;
               end else if (!level_in && dt >= TIME_BITS'(cfg.off_time)) begin
                  level_in = 1'b1;
                  last_in  = now_in;
               end
            end
            MODE_PATTERN: begin
               priority if (first_left_in != '0) begin
                  if (level_in && dt >= TIME_BITS'(cfg.on_time)) begin
                     level_in      = 1'b0;
                     last_in       = now_in;
                     first_left_in = first_left_in - COUNT_BITS'(1);
                  end else if (!level_in && dt >= TIME_BITS'(cfg.off_time)) begin
                     level_in = 1'b1;
                     last_in  = now_in;
                  end
               end else if (second_left_in != '0) begin
                  // second group starts after the group gap
                  if (dt >= TIME_BITS'(cfg.group_gap)) begin
                     level_in       = 1'b1;
                     last_in        = now_in;
                     first_left_in  = second_left_in;
                     second_left_in = '0;
                  end
               end else if (repeat_in) begin
                  if (dt >= TIME_BITS'(cfg.end_gap)) begin
                     level_in       = 1'b1;
                     last_in        = now_in;
                     first_left_in  = first_total_in;
                     second_left_in = second_total_in;
                  end
               end else begin
                  mode_in  = MODE_OFF;
                  level_in = 1'b0;
               end
            end
            default: begin
               mode_in  = MODE_OFF;
               level_in = 1'b0;
            end
         endcase
      end
   end

   assign flags.led_level   = level_in;
   assign flags.led_changed = level_in != driven_ff;
   assign flags.is_lit_mode = ov_act || (mode_in != MODE_OFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff          <= '0;
         last_ff         <= '0;
         ov_start_ff     <= '1;
         ov_len_ff       <= '0;
         ov_lvl_ff       <= 1'b0;
         mode_ff         <= MODE_OFF;
         level_ff        <= 1'b0;
         driven_ff       <= 1'b0;
         repeat_ff       <= 1'b0;
         first_left_ff   <= '0;
         second_left_ff  <= '0;
         first_total_ff  <= '0;
         second_total_ff <= '0;
      end else if (item_vld) begin
         now_ff          <= now_in;
         last_ff         <= last_in;
         ov_start_ff     <= ov_start_in;
         ov_len_ff       <= ov_len_in;
         ov_lvl_ff       <= ov_lvl_in;
         mode_ff         <= mode_in;
         level_ff        <= level_in;
         driven_ff       <= level_in;
         repeat_ff       <= repeat_in;
         first_left_ff   <= first_left_in;
         second_left_ff  <= second_left_in;
         first_total_ff  <= first_total_in;
         second_total_ff <= second_total_in;
      end
   end

endmodule

// ===== sv/led_blink_pattern_generator.sv =====
`timescale 1ns / 1ps

// Indicator driver. Each request transaction is a millisecond tick or a command
// (on, off, toggle, blink, pattern, flash, pause) selected by req_tuser; each
// produces exactly one response transaction with the resulting level, a change
// flag and the lit-mode flag. One transaction is accepted every clock cycle
// unless back-pressure stalls it. The request sits in the input register, and
// the combinational state update in the core loads the output register, from
// which the response is presented. Back-pressure on rsp_tready stalls the
// input side only once both registers are full. The user must write timing
// registers on the csr channel only while idle; the block does not enforce it.
module led_blink_pattern_generator import lbpg_pkg::*; #(
   parameter int COUNT_BITS = 8,
   parameter int TIME_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [7:0] first_count, [15:8] second_count, [16] repeat_pattern, [32:17] duration
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [2:0] action
   input  logic [2:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] led_level, [1] led_changed, [2] is_lit_mode
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_data
);

   item_type  in_ff, in_in;
   logic      in_vld_ff;
   flags_type out_ff;
   logic      out_vld_ff;
   flags_type core_flags;
   cfg_type   cfg;
   logic      proc;

   // Stage handshakes
   assign proc       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || proc;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - 3){1'b0}}, out_ff};

   always_comb begin
      in_in.action         = action_type'(req_tuser);
      in_in.first_count    = req_tdata[7:0];
      in_in.second_count   = req_tdata[15:8];
      in_in.repeat_pattern = req_tdata[16];
      in_in.duration       = req_tdata[32:17];
   end

   lbpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lbpg_core #(
      .COUNT_BITS (COUNT_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .item_vld (proc),
      .item     (in_ff),
      .cfg      (cfg),
      .flags    (core_flags)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff <= in_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (proc) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         out_ff <= core_flags;
      end
   end

endmodule

// ===== verif/led_blink_pattern_generator_tb.sv =====
`timescale 1ns / 1ps

module led_blink_pattern_generator_tb;
   import lbpg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [2:0]               req_tuser = ACT_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [1:0]               csr_index = CSR_ON_TIME;
   logic [15:0]              csr_data = '0;

   led_blink_pattern_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus and expectation stores
   item_type  req_pending_q[$];
   flags_type led_expect_q[$];
   item_type  req_item;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;
   int miss_count    = 0;
   int cycle_count   = 0;

   // Indicator model state
   cfg_type     timing = '{ON_TIME_RST, OFF_TIME_RST, GROUP_GAP_RST, END_GAP_RST};
   logic [31:0] led_now       = '0;
   logic [31:0] led_last_flip = '0;
   logic [31:0] ovl_start     = '1;
   logic [15:0] ovl_len       = '0;
   logic        ovl_level     = 1'b0;
   mode_type    led_mode      = MODE_OFF;
   logic        lvl           = 1'b0;
   logic        lvl_driven    = 1'b0;
   logic [7:0]  grp1_left     = '0;
   logic [7:0]  grp2_left     = '0;
   logic [7:0]  grp1_total    = '0;
   logic [7:0]  grp2_total    = '0;
   logic        rep_on        = 1'b0;

   function automatic logic ovl_active();
      logic [31:0] since;
      since = led_now - ovl_start;
      return since <= {16'd0, ovl_len};
   endfunction

   function automatic logic lit_now();
      return ovl_active() || led_mode != MODE_OFF;
   endfunction

   function automatic void flip_to(logic v);
      lvl = v;
      led_last_flip = led_now;
   endfunction

   // Move the level along the blink / pattern timing
   function automatic void led_advance();
      logic [31:0] dt;
      dt = led_now - led_last_flip;
      if (ovl_active()) begin
         lvl = ovl_level;
      end else if (led_mode == MODE_ON || led_mode == MODE_OFF) begin
         lvl = (led_mode == MODE_ON);
      end else if (led_mode == MODE_BLINK) begin
         if (lvl && dt >= timing.on_time)
            flip_to(1'b0);
         else if (!lvl && dt >= timing.off_time)
            flip_to(1'b1);
      end else if (grp1_left != 0) begin
         if (lvl && dt >= timing.on_time) begin
            flip_to(1'b0);
            grp1_left--;
         end else if (!lvl && dt >= timing.off_time) begin
            flip_to(1'b1);
         end
      end else if (grp2_left != 0) begin
         if (dt >= timing.group_gap) begin
            flip_to(1'b1);
            grp1_left = grp2_left;
            grp2_left = '0;
         end
      end else if (rep_on) begin
         if (dt >= timing.end_gap) begin
            flip_to(1'b1);
            grp1_left = grp1_total;
            grp2_left = grp2_total;
         end
      end else begin
         led_mode = MODE_OFF;
         lvl = 1'b0;
      end
   endfunction

   function automatic void set_steady(logic en);
      led_mode = en ? MODE_ON : MODE_OFF;
      lvl = en;
      led_advance();
   endfunction

   // Apply one accepted request and queue the response it must produce
   function automatic void led_step(item_type it);
      flags_type want;
      case (it.action)
         ACT_TICK: begin
            led_now++;
            led_advance();
         end
         ACT_ON:     set_steady(1'b1);
         ACT_OFF:    set_steady(1'b0);
         ACT_TOGGLE: set_steady(!lit_now());
         ACT_BLINK: begin
            if (led_mode != MODE_BLINK) begin
               led_mode = MODE_BLINK;
               flip_to(1'b1);
            end
            led_advance();
         end
         ACT_PATTERN: begin
            rep_on = it.repeat_pattern;
            if (led_mode != MODE_PATTERN || grp1_total != it.first_count ||
                grp2_total != it.second_count) begin
               led_mode   = MODE_PATTERN;
               grp1_total = it.first_count;
               grp2_total = it.second_count;
               grp1_left  = it.first_count;
               grp2_left  = it.second_count;
               flip_to(1'b1);
            end
            led_advance();
         end
         default: begin
            // flash or pause overlay
            ovl_start = led_now;
            ovl_len   = it.duration;
            ovl_level = (it.action == ACT_FLASH);
            led_advance();
         end
      endcase
      want.led_level   = lvl;
      want.led_changed = (lvl != lvl_driven);
      want.is_lit_mode = lit_now();
      lvl_driven = lvl;
      led_expect_q.push_back(want);
   endfunction

   function automatic void note_miss(string what, int want, int got);
      miss_count++;
      if (miss_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   // Request driver
   always @(posedge clock) begin : req_drive
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            led_step(req_item);
         if (!req_tvalid || req_tready) begin
            if (req_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_item = req_pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, req_item.duration, req_item.repeat_pattern,
                              req_item.second_count, req_item.first_count};
               req_tuser  <= req_item.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin : rsp_check
      flags_type got;
      flags_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = flags_type'(rsp_tdata[2:0]);
            if (led_expect_q.size() == 0) begin
               note_miss("unexpected transaction, led_level", -1, got.led_level);
            end else begin
               want = led_expect_q.pop_front();
               if (got.led_level != want.led_level)
                  note_miss("led_level", want.led_level, got.led_level);
               if (got.led_changed != want.led_changed)
                  note_miss("led_changed", want.led_changed, got.led_changed);
               if (got.is_lit_mode != want.is_lit_mode)
                  note_miss("is_lit_mode", want.is_lit_mode, got.is_lit_mode);
            end
         end
         rsp_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off countdown
   always @(posedge clock) begin
      if (hold_cycles != 0)
         hold_cycles <= hold_cycles - 1;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic item_type make_item(action_type a, int c1, int c2, bit rep, int dur);
      item_type it;
      it.action         = a;
      it.first_count    = 8'(c1);
      it.second_count   = 8'(c2);
      it.repeat_pattern = rep;
      it.duration       = 16'(dur);
      return it;
   endfunction

   function automatic item_type noise_item(action_type a);
      return make_item(a, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 1), $urandom_range(0, 65535));
   endfunction

   // Command with mostly small counts and durations so patterns complete
   function automatic item_type rand_command();
      item_type it;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)      it = noise_item(ACT_ON);
      else if (pick < 20) it = noise_item(ACT_OFF);
      else if (pick < 30) it = noise_item(ACT_TOGGLE);
      else if (pick < 48) it = noise_item(ACT_BLINK);
      else if (pick < 75) it = noise_item(ACT_PATTERN);
      else if (pick < 88) it = noise_item(ACT_FLASH);
      else                it = noise_item(ACT_PAUSE);
      if ($urandom_range(0, 99) < 88) begin
         it.first_count  = 8'($urandom_range(0, 3));
         it.second_count = 8'($urandom_range(0, 3));
         it.duration     = 16'($urandom_range(0, 12));
      end
      return it;
   endfunction

   // Commands each followed by a run of ticks
   task automatic queue_random(int n);
      int left;
      int run;
      left = n;
      while (left > 0) begin
         req_pending_q.push_back(rand_command());
         left--;
         run = $urandom_range(0, 25);
         while (run > 0 && left > 0) begin
            req_pending_q.push_back(noise_item(ACT_TICK));
            run--;
            left--;
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (req_pending_q.size() != 0 || req_tvalid || led_expect_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ON_TIME:   timing.on_time   = val;
         CSR_OFF_TIME:  timing.off_time  = val;
         CSR_GROUP_GAP: timing.group_gap = val;
         CSR_END_GAP:   timing.end_gap   = val;
      endcase
      @(posedge clock);
   endtask

   task automatic load_timing(int on_t, int off_t, int gap_t, int end_t);
      csr_write(CSR_ON_TIME, 16'(on_t));
      csr_write(CSR_OFF_TIME, 16'(off_t));
      csr_write(CSR_GROUP_GAP, 16'(gap_t));
      csr_write(CSR_END_GAP, 16'(end_t));
   endtask

   task automatic run_phase(int on_t, int off_t, int gap_t, int end_t,
                            int idle, int stall, int n);
      wait_drained();
      load_timing(on_t, off_t, gap_t, end_t);
      send_idle_pct <= idle;
      rsp_stall_pct <= stall;
      queue_random(n);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed commands at reset timing
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_TOGGLE, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_TOGGLE, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_ON, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_OFF, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_BLINK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_BLINK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_PATTERN, 2, 1, 1, 0));
      // same counts keep the counters, only the repeat flag changes
      req_pending_q.push_back(make_item(ACT_PATTERN, 2, 1, 0, 0));
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_PATTERN, 255, 255, 1, 65535));
      req_pending_q.push_back(make_item(ACT_FLASH, 255, 255, 1, 65535));
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_TOGGLE, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_PAUSE, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      // both groups empty: off without repeat, lit with repeat
      req_pending_q.push_back(make_item(ACT_PATTERN, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_PATTERN, 0, 0, 1, 0));
      req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));
      req_pending_q.push_back(make_item(ACT_FLASH, 0, 0, 0, 2));
      req_pending_q.push_back(make_item(ACT_ON, 0, 0, 0, 0));
      repeat (4) req_pending_q.push_back(make_item(ACT_TICK, 0, 0, 0, 0));

      run_phase(3, 2, 5, 7, 0, 0, 250);
      run_phase(0, 0, 0, 0, 69, 0, 200);
      run_phase(1, 4, 2, 3, 0, 69, 250);
      run_phase(65535, 0, 65535, 0, 7, 7, 150);

      // Receiver holds off while the sender keeps offering
      wait_drained();
      load_timing(2, 1, 0, 65535);
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;
      hold_cycles <= 150;
      queue_random(80);
      // sender pauses until every response is back
      wait_drained();
      queue_random(80);

      run_phase($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                $urandom_range(0, 6), 7, 7, 200);

      wait_drained();
      repeat (8) @(posedge clock);
      if (miss_count == 0 && led_expect_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
